[design/tswa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tswa_pkg;

   // Command codes carried on the request channel.
   typedef enum logic [1:0] {
      CMD_STAMP = 2'd0,
      CMD_RESET = 2'd1,
      CMD_PAUSE = 2'd2,
      CMD_PLAY  = 2'd3
   } tswa_cmd_type;

   // Playback stage, one-hot.
   typedef enum logic [2:0] {
      STAGE_CLEAR = 3'b001,
      STAGE_HOLD  = 3'b010,
      STAGE_RUN   = 3'b100
   } tswa_stage_type;

   localparam int unsigned STAMP_W = 32;
   localparam int unsigned US_W    = 33;
   localparam int unsigned MS_W    = 32;
   localparam int unsigned PLAY_W  = 42;
   localparam int unsigned GAP_W   = 35;
   localparam int unsigned TOTAL_W = 64;

   // Microseconds in one tenth of a second and in one millisecond.
   localparam logic [16:0] TENTH_US = 17'd100000;
   localparam logic [9:0]  MS_US    = 10'd1000;

   // Wrap correction is the stamp range plus one; half of it splits small
   // backward steps from wraps.
   localparam logic signed [GAP_W-1:0] WRAP_ADD = 35'sd6553600001;
   localparam logic signed [GAP_W-1:0] NEG_HALF = -35'sd3276800000;

   // One converted request, passed from the input register to the core.
   typedef struct packed {
      tswa_cmd_type             command;
      logic [US_W-1:0]          now_us;
      logic [PLAY_W-1:0]        play_us;
   } tswa_work_type;

endpackage

`default_nettype wire

[design/tswa_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tswa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] raw_stamp;
   logic [31:0] pause_elapsed_ms;

   modport source (output valid, command, raw_stamp, pause_elapsed_ms, input ready);
   modport sink   (input valid, command, raw_stamp, pause_elapsed_ms, output ready);
endinterface

`default_nettype wire

[design/tswa_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tswa_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] accumulated_us;
   logic        advanced;

   modport source (output valid, accumulated_us, advanced, input ready);
   modport sink   (input valid, accumulated_us, advanced, output ready);
endinterface

`default_nettype wire

[design/timestamp_wrap_accumulator.sv]
// A stamp transaction passes the input register, then the result register.
// One transaction per cycle unless the result side stalls; stage, total and
// last stamp registers update in the same cycle, for the next transaction.
// Reset, pause and play commands produce no result.
// Synchronous active-high reset clears the stage to reset, the total and
// the last stamp to zero, and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_wrap_accumulator
   import tswa_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tswa_req_if.sink   req_bus,
   tswa_rsp_if.source rsp_bus
);

   logic          advance;
   logic          work_valid;
   tswa_work_type work;

   // Input register with stamp and pause conversion.
   tswa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .work_valid (work_valid),
      .work       (work)
   );

   // State update and result register.
   tswa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work       (work),
      .advance    (advance),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

[design/tswa_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tswa_front
   import tswa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   tswa_req_if.sink      req_bus,
   input  wire logic     advance,
   output logic          work_valid,
   output tswa_work_type work
);

   logic          valid_ff;
   logic          valid_in;
   tswa_work_type work_ff;
   tswa_work_type work_in;
   logic          load;

   // The register can take a transaction when empty or when the core drains it.
   assign req_bus.ready = !valid_ff || advance;
   assign load          = req_bus.valid && req_bus.ready;

   // Convert the stamp and the pause time to microseconds on the way in.
   always_comb begin
      work_in.command = tswa_cmd_type'(req_bus.command);
      work_in.now_us  = US_W'(req_bus.raw_stamp[31:16]) * US_W'(TENTH_US)
                      + US_W'({req_bus.raw_stamp[15:0], 1'b0});
      work_in.play_us = PLAY_W'(req_bus.pause_elapsed_ms) * PLAY_W'(MS_US);
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
      end
   end

   assign work_valid = valid_ff;
   assign work       = work_ff;

endmodule

`default_nettype wire

[design/tswa_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module tswa_core
   import tswa_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           work_valid,
   input  wire tswa_work_type  work,
   output logic                advance,
   tswa_rsp_if.source          rsp_bus
);

   tswa_stage_type          stage_ff;
   tswa_stage_type          stage_in;
   logic [TOTAL_W-1:0]      total_ff;
   logic [TOTAL_W-1:0]      total_in;
   logic [US_W-1:0]         last_ff;
   logic [US_W-1:0]         last_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [TOTAL_W-1:0]      out_acc_ff;
   logic [TOTAL_W-1:0]      out_acc_in;
   logic                    out_adv_ff;
   logic                    out_adv_in;
   logic                    fire;
   logic signed [GAP_W-1:0] delta;
   logic signed [GAP_W-1:0] gap;
   logic [TOTAL_W-1:0]      sum;
   logic                    positive;

   // The core moves when the result register is empty or being taken.
   assign advance = !out_valid_ff || rsp_bus.ready;
   assign fire    = advance && work_valid;

   // Signed gap from the last accepted stamp, with wrap correction.
   always_comb begin
      delta    = $signed({2'b00, work.now_us}) - $signed({2'b00, last_ff});
      gap      = (delta <= NEG_HALF) ? delta + WRAP_ADD : delta;
      sum      = total_ff + {{(TOTAL_W-GAP_W){gap[GAP_W-1]}}, gap};
      positive = !gap[GAP_W-1] && (gap != '0);
   end

   // Next state and result for the transaction in the input register.
   always_comb begin
      stage_in     = stage_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      out_acc_in   = out_acc_ff;
      out_adv_in   = out_adv_ff;
      if (advance) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         case (work.command)
            CMD_RESET: begin
               stage_in = STAGE_CLEAR;
            end
            CMD_PAUSE: begin
               stage_in = STAGE_HOLD;
            end
            CMD_PLAY: begin
               total_in = total_ff + TOTAL_W'(work.play_us);
            end
            CMD_STAMP: begin
               out_valid_in = 1'b1;
               out_adv_in   = 1'b0;
               case (stage_ff)
                  STAGE_CLEAR: begin
                     stage_in   = STAGE_RUN;
                     total_in   = '0;
                     out_acc_in = '0;
                  end
                  STAGE_HOLD: begin
                     stage_in   = STAGE_RUN;
                     out_acc_in = total_ff;
                  end
                  default: begin
                     out_acc_in = sum;
                     if (positive) begin
                        total_in   = sum;
                        last_in    = work.now_us;
                        out_adv_in = 1'b1;
                     end
                  end
               endcase
            end
            default: begin
               stage_in = stage_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= STAGE_CLEAR;
         total_ff     <= '0;
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= stage_in;
         total_ff     <= total_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      out_acc_ff <= out_acc_in;
      out_adv_ff <= out_adv_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.accumulated_us = out_acc_ff;
   assign rsp_bus.advanced       = out_adv_ff;

endmodule

`default_nettype wire

[design/tswa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tswa_checker
   import tswa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_command,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_accumulated_us,
   input wire logic        rsp_advanced
);

   // Both pipeline registers are empty after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready after reset");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accumulated_us)
         && $stable(rsp_advanced))
      else $error("stalled result changed");

   // A fresh result must follow an accepted stamp transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && !reset
         && (req_command == CMD_STAMP), 2))
      else $error("result without a matching stamp transaction");

endmodule

bind timestamp_wrap_accumulator tswa_checker u_tswa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_command        (req_bus.command),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_accumulated_us (rsp_bus.accumulated_us),
   .rsp_advanced       (rsp_bus.advanced)
);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import tswa_pkg::*;

   // Stamp range in microseconds and the backward step beyond which a stamp is a wrap.
   localparam longint MAX_STAMP_US  = 64'sd6553600000;
   localparam longint HALF_RANGE_US = 64'sd3276800000;
   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned BURST_AT     = 700;
   localparam int unsigned BURST_ITEMS  = 40;
   localparam int unsigned LONG_HOLD    = 150;

   // Tracks the accumulator state and the results still owed by the block.
   class stamp_scoreboard;
      typedef struct {
         logic [63:0] accumulated_us;
         logic        advanced;
      } stamp_result_type;

      tswa_stage_type   stage;
      logic [63:0]      total_us;
      logic [32:0]      last_us;
      stamp_result_type owed_results[$];
      int unsigned      fail_count;

      function new();
         stage      = STAGE_CLEAR;
         total_us   = '0;
         last_us    = '0;
         fail_count = 0;
      endfunction

      // Tenths of a second plus 2 us ticks, in microseconds.
      function logic [63:0] stamp_to_us(logic [31:0] raw);
         return 64'(raw[31:16]) * 64'd100000 + 64'(raw[15:0]) * 64'd2;
      endfunction

      // Updates the state for one accepted transaction and queues its result.
      function void note_command(tswa_cmd_type cmd, logic [31:0] raw, logic [31:0] ms);
         longint           now_us;
         longint           prev_us;
         longint           gap;
         stamp_result_type res;
         case (cmd)
            CMD_RESET: stage = STAGE_CLEAR;
            CMD_PAUSE: stage = STAGE_HOLD;
            CMD_PLAY:  total_us = total_us + 64'(ms) * 64'd1000;
            default: begin
               res.advanced = 1'b0;
               if (stage == STAGE_CLEAR) begin
                  stage              = STAGE_RUN;
                  total_us           = '0;
                  res.accumulated_us = '0;
               end else if (stage == STAGE_HOLD) begin
                  stage              = STAGE_RUN;
                  res.accumulated_us = total_us;
               end else begin
                  now_us  = stamp_to_us(raw);
                  prev_us = longint'({31'd0, last_us});
                  gap     = now_us - prev_us;
                  // A large backward step means the stamp counter wrapped.
                  if (gap < 0 && -gap >= HALF_RANGE_US) begin
                     gap = MAX_STAMP_US - prev_us + now_us + 1;
                  end
                  res.accumulated_us = total_us + gap;
                  if (gap > 0) begin
                     total_us     = res.accumulated_us;
                     last_us      = now_us[32:0];
                     res.advanced = 1'b1;
                  end
               end
               owed_results.push_back(res);
            end
         endcase
      endfunction

      // Compares one result from the block with the oldest owed result.
      function void check_result(logic [63:0] accumulated_us, logic advanced);
         stamp_result_type exp;
         if (owed_results.size() == 0) begin
            $error("result with nothing owed: accumulated_us %0d advanced %0b",
                   accumulated_us, advanced);
            fail_count++;
            return;
         end
         exp = owed_results.pop_front();
         if (accumulated_us !== exp.accumulated_us) begin
            $error("accumulated_us: expected %0d, actual %0d",
                   exp.accumulated_us, accumulated_us);
            fail_count++;
         end
         if (advanced !== exp.advanced) begin
            $error("advanced: expected %0b, actual %0b", exp.advanced, advanced);
            fail_count++;
         end
      endfunction

      function int unsigned owed_count();
         return owed_results.size();
      endfunction

      // Any result still owed at the end of the run is a failure.
      function void report_leftovers();
         foreach (owed_results[i]) begin
            $error("result never arrived: accumulated_us %0d advanced %0b",
                   owed_results[i].accumulated_us, owed_results[i].advanced);
            fail_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tswa_req_if req_bus ();
   tswa_rsp_if rsp_bus ();

   timestamp_wrap_accumulator u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   stamp_scoreboard board = new();

   logic        idle_enabled;
   logic        long_hold_due;
   int unsigned burst_left;
   logic [31:0] last_raw;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap lengths: mostly short, a few long.
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   // Offers one transaction, waits until it is accepted, then maybe idles.
   task automatic drive_request(tswa_cmd_type cmd, logic [31:0] raw, logic [31:0] ms);
      req_bus.valid            <= 1'b1;
      req_bus.command          <= cmd;
      req_bus.raw_stamp        <= raw;
      req_bus.pause_elapsed_ms <= ms;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_command(cmd, raw, ms);
      if (burst_left > 0) begin
         burst_left--;
      end else if (idle_enabled && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   task automatic send_stamp(logic [31:0] raw);
      drive_request(CMD_STAMP, raw, $urandom);
      last_raw = raw;
   endtask

   // Stops offering and waits until every owed result has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.owed_count() != 0);
   endtask

   // Random transaction, biased toward plausible stamp sequences in the play stage.
   task automatic send_random_item();
      int unsigned pick;
      int unsigned kind;
      logic [31:0] raw;
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            raw = last_raw + $urandom_range(1, 20000);
         end else if (kind < 58) begin
            raw = last_raw + {16'($urandom_range(1, 50)), 16'h0000};
         end else if (kind < 70) begin
            raw = last_raw - $urandom_range(0, 5000);
         end else if (kind < 82) begin
            raw = $urandom;
         end else if (kind < 91) begin
            raw = {16'hFFFF - 16'($urandom_range(0, 3)), 16'($urandom)};
         end else begin
            raw = {16'($urandom_range(0, 3)), 16'($urandom)};
         end
         send_stamp(raw);
      end else if (pick < 88) begin
         drive_request(CMD_PLAY, $urandom,
                       ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 10000)) : $urandom);
      end else if (pick < 94) begin
         drive_request(CMD_PAUSE, $urandom, $urandom);
      end else begin
         drive_request(CMD_RESET, $urandom, $urandom);
      end
   endtask

   // Result side: checks each transaction and stalls at random or on request.
   initial begin
      int unsigned hold_cycles;
      hold_cycles   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            board.check_result(rsp_bus.accumulated_us, rsp_bus.advanced);
         end
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_cycles   = LONG_HOLD;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            hold_cycles   = gap_length();
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Main stimulus.
   initial begin
      reset                    = 1'b1;
      idle_enabled             = 1'b0;
      long_hold_due            = 1'b0;
      burst_left               = 0;
      last_raw                 = '0;
      req_bus.valid            <= 1'b0;
      req_bus.command          <= CMD_STAMP;
      req_bus.raw_stamp        <= '0;
      req_bus.pause_elapsed_ms <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: stage transitions, field extremes, backward steps and wraps.
      send_stamp(32'h1234_5678);
      send_stamp(32'h0000_0000);
      send_stamp(32'h0000_0001);
      send_stamp(32'h0001_0000);
      send_stamp(32'h0000_FFFF);
      send_stamp(32'h0000_FFF0);
      send_stamp(32'hFFFF_FFFF);
      // Wrap whose corrected difference is still negative.
      send_stamp(32'h0000_0000);
      send_stamp(32'h0000_8000);
      send_stamp(32'h8000_0000);
      // Backward step of exactly half the range counts as a wrap.
      send_stamp(32'h0000_0000);
      drive_request(CMD_PLAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drive_request(CMD_PLAY, 32'h0000_0000, 32'h0000_0000);
      send_stamp(32'h0000_0100);
      drive_request(CMD_PAUSE, 32'h0000_0000, 32'h0000_0000);
      send_stamp(32'h0000_0000);
      send_stamp(32'hFFFF_FFFF);
      drive_request(CMD_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drive_request(CMD_PLAY, 32'h0000_0000, 32'd1234);
      send_stamp(32'hFFFF_0000);
      send_stamp(32'hFFFF_0000);
      drive_request(CMD_PAUSE, 32'h0000_0000, 32'h0000_0000);
      drive_request(CMD_RESET, 32'h0000_0000, 32'h0000_0000);
      send_stamp(32'h0000_0002);
      send_stamp(32'h0000_0003);
      drain_results();

      // Random: a first stretch back to back, then idling on both sides.
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) idle_enabled = 1'b1;
         if (i == BURST_AT) begin
            // Let the result side hold off while transactions keep coming.
            drain_results();
            long_hold_due = 1'b1;
            burst_left    = BURST_ITEMS;
         end
         if (i == 1000) drain_results();
         send_random_item();
      end

      drain_results();
      repeat (8) @(posedge clock);
      board.report_leftovers();
      if (board.fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(10_000_000);
      $display("tb_top failed");
      $finish;
   end

endmodule
